[src/assert_macros.svh]
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

// Property checked at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: label");

`endif

[src/atrs_pkg.sv]
package atrs_pkg;

    // Field widths.
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PROD_W   = 2 * TICK_W;

    // Divider: two quotient bits per cycle.
    localparam int unsigned DIV_BITS_PER_CYC = 2;
    localparam int unsigned DIV_CYCLES = PROD_W / DIV_BITS_PER_CYC;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_CYCLES);

    // Highest setpoint the actuator may be given.
    localparam logic [POS_W-1:0] POS_LIMIT = 11'd1066;

    // Sequence phases as shown on the result word.
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_HOLD      = 3'd1,
        PH_RAMP_UP   = 3'd2,
        PH_TOP_HOLD  = 3'd3,
        PH_RAMP_DOWN = 3'd4,
        PH_SETTLE    = 3'd5,
        PH_END       = 3'd6
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TICKS      = 3'd0,
        CFG_RAMP_UP_TICKS   = 3'd1,
        CFG_TOP_HOLD_TICKS  = 3'd2,
        CFG_RAMP_DOWN_TICKS = 3'd3,
        CFG_SETTLE_TICKS    = 3'd4,
        CFG_MAX_POSITION    = 3'd5,
        CFG_MIN_POSITION    = 3'd6
    } t_cfg_idx;

    // Sequencer states of the datapath.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    // Clamp a value to the setpoint limit.
    function automatic logic [POS_W-1:0] clamp_pos(input logic [PROD_W:0] v);
        logic [POS_W-1:0] res;
        if (v > {{(PROD_W + 1 - POS_W){1'b0}}, POS_LIMIT}) begin
            res = POS_LIMIT;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

[src/actuator_test_ramp_sequencer.sv]
// Actuator test ramp sequencer.
// One input word per control tick arrives on the s_axis channel (enable,
// action code, start request); for each one exactly one result word leaves on
// the m_axis channel with the phase, the setpoint and the two status flags as
// they stand after that tick. Registers are written on the cfg channel, which
// is always ready; the user must write them only while no tick is in flight,
// as the block itself does not enforce this. A tick in a ramp phase that does
// not end the ramp computes the setpoint from (distance * ticks left) / ramp
// length: a 16x16 multiply, then a shared restoring divider that yields two
// quotient bits a cycle, then a step to form and clamp the setpoint; its result
// word is then loaded once the output register is free. Every other tick goes
// straight from acceptance to loading its result word once the register is
// free. The next word is accepted only after the last result word is loaded.
// s_axis_tready is high only while the sequencer is idle. A result word sits
// in the output register until it is taken; the next tick may be accepted and
// worked on meanwhile, and its result waits until the register is free.
// Synchronous reset puts the sequence in idle with the setpoint at zero, the
// not-running flag set and the registers at their reset values.
module actuator_test_ramp_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // enable[0], action_code[8:1], start_req[9]
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // phase[2:0], position_setpoint[13:3],
                                        // sequence_done[14], test_not_running[15]
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned TW = atrs_pkg::TICK_W;
    localparam int unsigned PW = atrs_pkg::PROD_W;
    localparam int unsigned SW = atrs_pkg::POS_W;

    // Configuration registers.
    logic [TW-1:0] r_hold_ticks, r_ramp_up_ticks, r_top_hold_ticks;
    logic [TW-1:0] r_ramp_down_ticks, r_settle_ticks, r_max_position, r_min_position;

    // Sequence state.
    atrs_pkg::t_phase r_phase, n_phase;
    logic [TW-1:0]    r_tick_timer, n_tick_timer;
    logic [atrs_pkg::CODE_W-1:0] r_latched_code, n_latched_code;
    logic [SW-1:0]    r_setpoint, n_setpoint;
    logic             r_done, n_done;
    logic             r_not_run, n_not_run;
    logic             n_need_ramp;

    // Sequencer and arithmetic unit.
    atrs_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_quot;
    logic [TW-1:0]    r_rem;
    logic [atrs_pkg::DIV_CNT_W-1:0] r_cnt;

    // Output register.
    logic             r_m_valid;
    logic [15:0]      r_m_data;

    // Control from the sequencer.
    logic in_ready, mul_en, div_en, fin_en, out_load;
    logic in_acc, out_free;

    // Input fields.
    logic                        in_en, in_start;
    logic [atrs_pkg::CODE_W-1:0] in_code;

    // Tick evaluation.
    logic [TW-1:0] tmr_dec;
    logic          step_next;

    // Ramp operands.
    logic          ramp_up;
    logic [TW-1:0] ramp_from, ramp_to, ramp_len, ramp_diff;
    logic          ramp_rising;

    // Divider step results.
    logic [PW-1:0] d_quo;
    logic [TW-1:0] d_rem;
    logic [TW:0]   d_trial;

    // Ramp setpoint.
    logic [SW-1:0] fin_setpoint;

    assign in_en    = s_axis_tdata[0];
    assign in_code  = s_axis_tdata[8:1];
    assign in_start = s_axis_tdata[9];

    assign in_acc   = s_axis_tvalid && in_ready;
    assign out_free = !r_m_valid || m_axis_tready;

    // Configuration channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks      <= '0;
            r_ramp_up_ticks   <= TW'(1);
            r_top_hold_ticks  <= '0;
            r_ramp_down_ticks <= TW'(1);
            r_settle_ticks    <= '0;
            r_max_position    <= '0;
            r_min_position    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                atrs_pkg::CFG_HOLD_TICKS:      r_hold_ticks      <= i_cfg_data;
                atrs_pkg::CFG_RAMP_UP_TICKS:   r_ramp_up_ticks   <= i_cfg_data;
                atrs_pkg::CFG_TOP_HOLD_TICKS:  r_top_hold_ticks  <= i_cfg_data;
                atrs_pkg::CFG_RAMP_DOWN_TICKS: r_ramp_down_ticks <= i_cfg_data;
                atrs_pkg::CFG_SETTLE_TICKS:    r_settle_ticks    <= i_cfg_data;
                atrs_pkg::CFG_MAX_POSITION:    r_max_position    <= i_cfg_data;
                atrs_pkg::CFG_MIN_POSITION:    r_min_position    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Timer decrement, saturating at zero.
    assign tmr_dec   = (r_tick_timer == '0) ? '0 : r_tick_timer - TW'(1);
    assign step_next = (tmr_dec <= TW'(1));

    // Evaluate one tick; ramp setpoints are filled in later by the divider.
    always_comb begin
        n_phase        = r_phase;
        n_tick_timer   = r_tick_timer;
        n_latched_code = r_latched_code;
        n_setpoint     = r_setpoint;
        n_done         = r_done;
        n_not_run      = r_not_run;
        n_need_ramp    = 1'b0;
        case (r_phase)
            atrs_pkg::PH_HOLD, atrs_pkg::PH_RAMP_UP, atrs_pkg::PH_TOP_HOLD,
            atrs_pkg::PH_RAMP_DOWN, atrs_pkg::PH_SETTLE: begin
                if (!in_en || (in_code != r_latched_code)) begin
                    n_phase    = atrs_pkg::PH_IDLE;
                    n_setpoint = '0;
                    n_done     = 1'b0;
                    n_not_run  = 1'b1;
                end else begin
                    n_tick_timer = tmr_dec;
                    case (r_phase)
                        atrs_pkg::PH_HOLD: begin
                            if (step_next) begin
                                n_phase      = atrs_pkg::PH_RAMP_UP;
                                n_tick_timer = r_ramp_up_ticks;
                                n_setpoint   = atrs_pkg::clamp_pos(
                                    (PW + 1)'(r_min_position));
                            end
                        end
                        atrs_pkg::PH_RAMP_UP: begin
                            if (step_next) begin
                                n_phase      = atrs_pkg::PH_TOP_HOLD;
                                n_tick_timer = r_top_hold_ticks;
                                n_setpoint   = atrs_pkg::clamp_pos(
                                    (PW + 1)'(r_max_position));
                            end else begin
                                n_need_ramp = 1'b1;
                            end
                        end
                        atrs_pkg::PH_TOP_HOLD: begin
                            if (step_next) begin
                                n_phase      = atrs_pkg::PH_RAMP_DOWN;
                                n_tick_timer = r_ramp_down_ticks;
                                n_setpoint   = atrs_pkg::clamp_pos(
                                    (PW + 1)'(r_max_position));
                            end
                        end
                        atrs_pkg::PH_RAMP_DOWN: begin
                            if (step_next) begin
                                n_phase      = atrs_pkg::PH_SETTLE;
                                n_tick_timer = r_settle_ticks;
                                n_setpoint   = atrs_pkg::clamp_pos(
                                    (PW + 1)'(r_min_position));
                            end else begin
                                n_need_ramp = 1'b1;
                            end
                        end
                        default: begin
                            if (step_next) begin
                                n_phase    = atrs_pkg::PH_END;
                                n_setpoint = '0;
                                n_done     = 1'b1;
                                n_not_run  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            atrs_pkg::PH_END: begin
                if (!in_en) begin
                    n_phase    = atrs_pkg::PH_IDLE;
                    n_setpoint = '0;
                    n_done     = 1'b0;
                    n_not_run  = 1'b1;
                end
            end
            default: begin
                n_phase = atrs_pkg::PH_IDLE;
                if (in_en && in_start) begin
                    n_latched_code = in_code;
                    n_phase        = atrs_pkg::PH_HOLD;
                    n_tick_timer   = r_hold_ticks;
                    n_setpoint     = '0;
                    n_done         = 1'b0;
                    n_not_run      = 1'b0;
                end
            end
        endcase
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            atrs_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = n_need_ramp ? atrs_pkg::ST_MUL : atrs_pkg::ST_OUT;
                end
            end
            atrs_pkg::ST_MUL: n_state = atrs_pkg::ST_DIV;
            atrs_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = atrs_pkg::ST_FIN;
                end
            end
            atrs_pkg::ST_FIN: n_state = atrs_pkg::ST_OUT;
            atrs_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = atrs_pkg::ST_IDLE;
                end
            end
            default: n_state = atrs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: control outputs.
    always_comb begin
        in_ready = 1'b0;
        mul_en   = 1'b0;
        div_en   = 1'b0;
        fin_en   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            atrs_pkg::ST_IDLE: in_ready = 1'b1;
            atrs_pkg::ST_MUL:  mul_en   = 1'b1;
            atrs_pkg::ST_DIV:  div_en   = 1'b1;
            atrs_pkg::ST_FIN:  fin_en   = 1'b1;
            atrs_pkg::ST_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    assign s_axis_tready = in_ready;

    // Ramp operands follow the phase: up runs min to max, down max to min.
    assign ramp_up     = (r_phase == atrs_pkg::PH_RAMP_UP);
    assign ramp_from   = ramp_up ? r_min_position : r_max_position;
    assign ramp_to     = ramp_up ? r_max_position : r_min_position;
    assign ramp_len    = ramp_up ? r_ramp_up_ticks : r_ramp_down_ticks;
    assign ramp_rising = (ramp_to >= ramp_from);
    assign ramp_diff   = ramp_rising ? (ramp_to - ramp_from) : (ramp_from - ramp_to);

    // Two restoring divide steps. A zero divisor gives a quotient of all ones.
    always_comb begin
        d_rem   = r_rem;
        d_quo   = r_quot;
        d_trial = '0;
        for (int k = 0; k < atrs_pkg::DIV_BITS_PER_CYC; k++) begin
            d_trial = {d_rem, d_quo[PW-1]};
            d_quo   = {d_quo[PW-2:0], 1'b0};
            if (d_trial >= {1'b0, ramp_len}) begin
                d_trial  = d_trial - {1'b0, ramp_len};
                d_quo[0] = 1'b1;
            end
            d_rem = d_trial[TW-1:0];
        end
    end

    // Setpoint from the quotient: step back from the target, clamped.
    always_comb begin
        if (ramp_rising) begin
            if ({{(PW - TW){1'b0}}, ramp_to} > r_quot) begin
                fin_setpoint = atrs_pkg::clamp_pos(
                    (PW + 1)'(ramp_to - r_quot[TW-1:0]));
            end else begin
                fin_setpoint = '0;
            end
        end else begin
            fin_setpoint = atrs_pkg::clamp_pos(
                {1'b0, r_quot} + (PW + 1)'(ramp_to));
        end
    end

    // Sequence and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= atrs_pkg::ST_IDLE;
            r_phase        <= atrs_pkg::PH_IDLE;
            r_tick_timer   <= '0;
            r_latched_code <= '0;
            r_setpoint     <= '0;
            r_done         <= 1'b0;
            r_not_run      <= 1'b1;
            r_cnt          <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_phase        <= n_phase;
                r_tick_timer   <= n_tick_timer;
                r_latched_code <= n_latched_code;
                r_setpoint     <= n_setpoint;
                r_done         <= n_done;
                r_not_run      <= n_not_run;
            end
            if (mul_en) begin
                r_cnt <= atrs_pkg::DIV_CNT_W'(atrs_pkg::DIV_CYCLES - 1);
            end else if (div_en) begin
                r_cnt <= r_cnt - atrs_pkg::DIV_CNT_W'(1);
            end
            if (fin_en) begin
                r_setpoint <= fin_setpoint;
            end
        end
    end

    // Multiply then divide through the shared quotient register.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_quot <= PW'(ramp_diff) * PW'(r_tick_timer);
            r_rem  <= '0;
        end else if (div_en) begin
            r_quot <= d_quo;
            r_rem  <= d_rem;
        end
    end

    // Output register holds the word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {r_not_run, r_done, r_setpoint, r_phase};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

[src/atrs_checker.sv]
`include "assert_macros.svh"

// Port-level checks of the ramp sequencer.
module atrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic [2:0]  chk_phase;
    logic [10:0] chk_setpoint;
    logic        chk_done, chk_not_run, chk_running;

    assign chk_phase    = m_axis_tdata[2:0];
    assign chk_setpoint = m_axis_tdata[13:3];
    assign chk_done     = m_axis_tdata[14];
    assign chk_not_run  = m_axis_tdata[15];
    assign chk_running  = (chk_phase != atrs_pkg::PH_IDLE) && (chk_phase != atrs_pkg::PH_END);

    // A stalled result word holds.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // One word at a time: no word is accepted in the cycle after another.
    `ASSERT_CLK_RST(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // The setpoint never passes the limit.
    `ASSERT_CLK_RST(a_setpoint_limit, i_clk, i_rst_n, m_axis_tvalid |-> chk_setpoint <= atrs_pkg::POS_LIMIT)

    // The done flag marks the end phase exactly; running phases clear not-running.
    `ASSERT_CLK_RST(a_flags_match_phase, i_clk, i_rst_n, m_axis_tvalid |-> (chk_done == (chk_phase == atrs_pkg::PH_END)) && (chk_not_run == !chk_running))

endmodule

bind actuator_test_ramp_sequencer atrs_checker u_atrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/actuator_test_ramp_sequencer_tb.sv]
`timescale 1ns / 1ps

module actuator_test_ramp_sequencer_tb;

    // Cycles waited after every outstanding status word has come back.
    localparam int unsigned SETTLE_CYCLES = 40;
    // Cycles in which no word moves on any channel before the run is abandoned.
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT = 50;

    // Status as it stands after one tick.
    typedef struct packed {
        atrs_pkg::t_phase                 phase;
        logic [atrs_pkg::POS_W-1:0]       setpoint;
        logic                             done;
        logic                             not_running;
    } t_seq_status;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [15:0]                      s_axis_tdata;  // enable[0], action_code[8:1],
                                                     // start_req[9]
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [15:0]                      m_axis_tdata;  // phase[2:0], position_setpoint[13:3],
                                                     // sequence_done[14],
                                                     // test_not_running[15]
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [atrs_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [atrs_pkg::TICK_W-1:0]      i_cfg_data;

    // Predictor state and its copy of the registers.
    atrs_pkg::t_phase                 seq_phase;
    logic [atrs_pkg::TICK_W-1:0]      countdown;
    logic [atrs_pkg::CODE_W-1:0]      held_code;
    logic [atrs_pkg::POS_W-1:0]       setpoint;
    logic                             done_q;
    logic                             not_running_q;
    logic [atrs_pkg::TICK_W-1:0]      cfg_regs [0:6];

    t_seq_status                      pending_status [$];
    int unsigned                      mismatches;
    int unsigned                      ticks_sent;
    int unsigned                      quiet_cycles;
    bit                               idling_on;

    actuator_test_ramp_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Setpoints never exceed the actuator limit.
    function automatic logic [atrs_pkg::POS_W-1:0] limit_setpoint(input logic [31:0] value);
        return (value > {21'd0, atrs_pkg::POS_LIMIT}) ? atrs_pkg::POS_LIMIT
                                                      : value[atrs_pkg::POS_W-1:0];
    endfunction

    // Linear interpolation from one position toward another with 'left' of 'len'
    // ticks remaining. A zero length yields an all-ones quotient, and the sum for a
    // falling ramp saturates rather than wrapping.
    function automatic logic [31:0] ramp_setpoint(
        input logic [atrs_pkg::TICK_W-1:0] from_pos,
        input logic [atrs_pkg::TICK_W-1:0] to_pos,
        input logic [atrs_pkg::TICK_W-1:0] left,
        input logic [atrs_pkg::TICK_W-1:0] len);
        logic [31:0] scaled;
        logic [31:0] quotient;
        logic [32:0] total;
        if (to_pos >= from_pos) begin
            scaled = {16'd0, to_pos - from_pos} * {16'd0, left};
        end else begin
            scaled = {16'd0, from_pos - to_pos} * {16'd0, left};
        end
        quotient = (len == '0) ? 32'hFFFF_FFFF : scaled / {16'd0, len};
        if (to_pos >= from_pos) begin
            return ({16'd0, to_pos} > quotient) ? {16'd0, to_pos} - quotient : 32'd0;
        end
        total = {17'd0, to_pos} + {1'b0, quotient};
        return total[32] ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    function automatic void abort_sequence();
        seq_phase     = atrs_pkg::PH_IDLE;
        setpoint      = '0;
        done_q        = 1'b0;
        not_running_q = 1'b1;
    endfunction

    function automatic void reset_sequencer();
        cfg_regs[atrs_pkg::CFG_HOLD_TICKS]      = 16'd0;
        cfg_regs[atrs_pkg::CFG_RAMP_UP_TICKS]   = 16'd1;
        cfg_regs[atrs_pkg::CFG_TOP_HOLD_TICKS]  = 16'd0;
        cfg_regs[atrs_pkg::CFG_RAMP_DOWN_TICKS] = 16'd1;
        cfg_regs[atrs_pkg::CFG_SETTLE_TICKS]    = 16'd0;
        cfg_regs[atrs_pkg::CFG_MAX_POSITION]    = 16'd0;
        cfg_regs[atrs_pkg::CFG_MIN_POSITION]    = 16'd0;
        seq_phase     = atrs_pkg::PH_IDLE;
        countdown     = '0;
        held_code     = '0;
        setpoint      = '0;
        done_q        = 1'b0;
        not_running_q = 1'b1;
    endfunction

    // Advances the sequence by one tick and returns the status that follows.
    function automatic t_seq_status step_sequencer(input logic en,
                                                   input logic [atrs_pkg::CODE_W-1:0] code,
                                                   input logic start);
        logic advance;
        if (seq_phase >= atrs_pkg::PH_HOLD && seq_phase <= atrs_pkg::PH_SETTLE) begin
            if (!en || code != held_code) begin
                abort_sequence();
            end else begin
                countdown = (countdown != '0) ? countdown - 1'b1 : '0;
                advance   = (countdown <= 16'd1);
                case (seq_phase)
                    atrs_pkg::PH_HOLD: begin
                        if (advance) begin
                            seq_phase = atrs_pkg::PH_RAMP_UP;
                            countdown = cfg_regs[atrs_pkg::CFG_RAMP_UP_TICKS];
                            setpoint  = limit_setpoint(
                                {16'd0, cfg_regs[atrs_pkg::CFG_MIN_POSITION]});
                        end
                    end
                    atrs_pkg::PH_RAMP_UP: begin
                        setpoint = limit_setpoint(ramp_setpoint(
                            cfg_regs[atrs_pkg::CFG_MIN_POSITION],
                            cfg_regs[atrs_pkg::CFG_MAX_POSITION], countdown,
                            cfg_regs[atrs_pkg::CFG_RAMP_UP_TICKS]));
                        if (advance) begin
                            seq_phase = atrs_pkg::PH_TOP_HOLD;
                            countdown = cfg_regs[atrs_pkg::CFG_TOP_HOLD_TICKS];
                            setpoint  = limit_setpoint(
                                {16'd0, cfg_regs[atrs_pkg::CFG_MAX_POSITION]});
                        end
                    end
                    atrs_pkg::PH_TOP_HOLD: begin
                        if (advance) begin
                            seq_phase = atrs_pkg::PH_RAMP_DOWN;
                            countdown = cfg_regs[atrs_pkg::CFG_RAMP_DOWN_TICKS];
                            setpoint  = limit_setpoint(
                                {16'd0, cfg_regs[atrs_pkg::CFG_MAX_POSITION]});
                        end
                    end
                    atrs_pkg::PH_RAMP_DOWN: begin
                        setpoint = limit_setpoint(ramp_setpoint(
                            cfg_regs[atrs_pkg::CFG_MAX_POSITION],
                            cfg_regs[atrs_pkg::CFG_MIN_POSITION], countdown,
                            cfg_regs[atrs_pkg::CFG_RAMP_DOWN_TICKS]));
                        if (advance) begin
                            seq_phase = atrs_pkg::PH_SETTLE;
                            countdown = cfg_regs[atrs_pkg::CFG_SETTLE_TICKS];
                            setpoint  = limit_setpoint(
                                {16'd0, cfg_regs[atrs_pkg::CFG_MIN_POSITION]});
                        end
                    end
                    default: begin
                        if (advance) begin
                            seq_phase     = atrs_pkg::PH_END;
                            setpoint      = '0;
                            done_q        = 1'b1;
                            not_running_q = 1'b1;
                        end
                    end
                endcase
            end
        end else if (seq_phase == atrs_pkg::PH_END) begin
            // Only a dropped enable leaves the end phase; the code is ignored.
            if (!en) begin
                abort_sequence();
            end
        end else begin
            seq_phase = atrs_pkg::PH_IDLE;
            if (en && start) begin
                held_code     = code;
                seq_phase     = atrs_pkg::PH_HOLD;
                countdown     = cfg_regs[atrs_pkg::CFG_HOLD_TICKS];
                setpoint      = '0;
                done_q        = 1'b0;
                not_running_q = 1'b0;
            end
        end
        return '{seq_phase, setpoint, done_q, not_running_q};
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Sends one tick word, with an occasional gap first, and records its status.
    task automatic send_tick(input logic en, input logic [atrs_pkg::CODE_W-1:0] code,
                             input logic start);
        int unsigned gap;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, start, code, en};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_status.push_back(step_sequencer(en, code, start));
        ticks_sent++;
    endtask

    task automatic send_noise();
        send_tick(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Stops sending and lets every outstanding status word come back.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Callers make sure the block is idle first.
    task automatic write_reg(input atrs_pkg::t_cfg_idx idx,
                             input logic [atrs_pkg::TICK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_regs[idx] = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Short tick counts mostly, so that sequences run to the end, with the
    // extremes and the occasional full-range value mixed in.
    task automatic randomise_registers();
        logic [atrs_pkg::TICK_W-1:0] value;
        int unsigned                 pick;
        for (int i = 0; i < 7; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 15);
                if (pick == 0) begin
                    value = 16'd0;
                end else if (pick == 1) begin
                    value = 16'hFFFF;
                end else if (pick == 2) begin
                    value = 16'($urandom);
                end else if (i >= int'(atrs_pkg::CFG_MAX_POSITION)) begin
                    value = 16'($urandom_range(0, 1200));
                end else begin
                    value = 16'($urandom_range(0, 7));
                end
                write_reg(atrs_pkg::t_cfg_idx'(i), value);
            end
        end
    endtask

    // A started sequence with the occasional abort, then the exit from the end.
    task automatic run_sequence(input int unsigned max_ticks);
        logic [atrs_pkg::CODE_W-1:0] code;
        int unsigned                 n;
        int unsigned                 roll;
        code = 8'($urandom);
        send_tick(1'b1, code, 1'b1);
        n = 0;
        while (n < max_ticks && seq_phase != atrs_pkg::PH_IDLE) begin
            roll = $urandom_range(0, 99);
            if (seq_phase == atrs_pkg::PH_END) begin
                if (roll < 40) begin
                    send_tick(1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    send_tick(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
                end
            end else if (roll < 2) begin
                send_tick(1'b0, code, 1'($urandom_range(0, 1)));
            end else if (roll < 4) begin
                send_tick(1'b1, code ^ (8'd1 << $urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            end else begin
                send_tick(1'b1, code, 1'($urandom_range(0, 1)));
            end
            n++;
        end
    endtask

    // Idle behaviour under the reset registers, then a start and a code abort.
    task automatic test_idle_and_start();
        send_tick(1'b0, 8'hA5, 1'b1);
        send_tick(1'b1, 8'h00, 1'b0);
        send_tick(1'b1, 8'hFF, 1'b1);
        send_tick(1'b1, 8'h7F, 1'b0);
    endtask

    // Every register at its maximum, then the longest ramp toward a clamped top.
    task automatic test_register_extremes();
        wait_drained();
        for (int i = 0; i < 7; i++) begin
            write_reg(atrs_pkg::t_cfg_idx'(i), 16'hFFFF);
        end
        send_tick(1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 8'h00, 1'b1);
        send_tick(1'b0, 8'h00, 1'b0);
        wait_drained();
        write_reg(atrs_pkg::CFG_HOLD_TICKS, 16'd0);
        write_reg(atrs_pkg::CFG_MIN_POSITION, 16'd0);
        send_tick(1'b1, 8'h5A, 1'b1);
        send_tick(1'b1, 8'h5A, 1'b0);
        send_tick(1'b1, 8'h5A, 1'b0);
        send_tick(1'b0, 8'h5A, 1'b0);
    endtask

    // Lengths and positions rewritten mid-ramp: a quotient past the target on
    // the way up, division by a zero length both ways, and an overflowing sum
    // on the way down; then the end phase ignoring a code change.
    task automatic test_ramp_corner_cases();
        wait_drained();
        write_reg(atrs_pkg::CFG_HOLD_TICKS, 16'd0);
        write_reg(atrs_pkg::CFG_RAMP_UP_TICKS, 16'd5);
        write_reg(atrs_pkg::CFG_TOP_HOLD_TICKS, 16'd0);
        write_reg(atrs_pkg::CFG_RAMP_DOWN_TICKS, 16'd5);
        write_reg(atrs_pkg::CFG_SETTLE_TICKS, 16'd0);
        write_reg(atrs_pkg::CFG_MAX_POSITION, 16'd1000);
        write_reg(atrs_pkg::CFG_MIN_POSITION, 16'd0);
        send_tick(1'b1, 8'h3C, 1'b1);
        send_tick(1'b1, 8'h3C, 1'b0);
        send_tick(1'b1, 8'h3C, 1'b0);
        wait_drained();
        write_reg(atrs_pkg::CFG_RAMP_UP_TICKS, 16'd1);
        send_tick(1'b1, 8'h3C, 1'b0);
        wait_drained();
        write_reg(atrs_pkg::CFG_RAMP_UP_TICKS, 16'd0);
        send_tick(1'b1, 8'h3C, 1'b0);
        send_tick(1'b1, 8'h3C, 1'b0);
        send_tick(1'b1, 8'h3C, 1'b0);
        wait_drained();
        write_reg(atrs_pkg::CFG_RAMP_DOWN_TICKS, 16'd0);
        send_tick(1'b1, 8'h3C, 1'b0);
        wait_drained();
        write_reg(atrs_pkg::CFG_MIN_POSITION, 16'd5);
        send_tick(1'b1, 8'h3C, 1'b0);
        wait_drained();
        write_reg(atrs_pkg::CFG_RAMP_DOWN_TICKS, 16'd5);
        write_reg(atrs_pkg::CFG_MIN_POSITION, 16'd0);
        send_tick(1'b1, 8'h3C, 1'b0);
        send_tick(1'b1, 8'h3C, 1'b0);
        send_tick(1'b1, 8'h3C, 1'b0);
        send_tick(1'b1, 8'hC3, 1'b1);
        send_tick(1'b0, 8'hC3, 1'b0);
    endtask

    // Random registers between bursts of sequences; a new setting may land
    // while a sequence is still part way through.
    task automatic test_random_sequences(input int unsigned tick_goal);
        while (ticks_sent < tick_goal) begin
            wait_drained();
            randomise_registers();
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6)) send_noise();
                end
                run_sequence($urandom_range(10, 60));
            end
        end
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_steady_flow(input int unsigned tick_goal);
        idling_on = 1'b0;
        test_random_sequences(tick_goal);
    endtask

    // Result side: ready with random stall bursts while idling is on.
    initial begin : result_ready
        int unsigned burst;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 14);
                m_axis_tready = 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Each status word against the oldest prediction.
    always @(posedge i_clk) begin : check_status
        t_seq_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("status word 0x%h with none expected",
                                          m_axis_tdata));
            end else begin
                want = pending_status.pop_front();
                if (m_axis_tdata[2:0] !== want.phase) begin
                    report_mismatch($sformatf("phase %0d, expected %0d",
                                              m_axis_tdata[2:0], want.phase));
                end
                if (m_axis_tdata[13:3] !== want.setpoint) begin
                    report_mismatch($sformatf("setpoint %0d, expected %0d",
                                              m_axis_tdata[13:3], want.setpoint));
                end
                if (m_axis_tdata[14] !== want.done) begin
                    report_mismatch($sformatf("sequence_done %b, expected %b",
                                              m_axis_tdata[14], want.done));
                end
                if (m_axis_tdata[15] !== want.not_running) begin
                    report_mismatch($sformatf("test_not_running %b, expected %b",
                                              m_axis_tdata[15], want.not_running));
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        mismatches    = 0;
        ticks_sent    = 0;
        quiet_cycles  = 0;
        idling_on     = 1'b1;
        reset_sequencer();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_and_start();
        test_register_extremes();
        test_ramp_corner_cases();
        test_random_sequences(1400);
        test_steady_flow(1600);
        wait_drained();

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
